/* rtl/core/graph_dfs_visit_order_defines.svh */
// Assertion helpers for the datapath design file.
// Both sample on the rising clock edge and are switched off while reset is low.
`ifndef GRAPH_DFS_VISIT_ORDER_DEFINES_SVH
`define GRAPH_DFS_VISIT_ORDER_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define GDFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define GDFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gdfs_pkg.sv */
`timescale 1ns / 1ps

package gdfs_pkg;

  // Field widths fixed by the item format.
  localparam int VTX_W     = 4;
  localparam int ROW_W     = 16;
  localparam int CNT_W     = 5;
  localparam int VTX_LIMIT = 16;

  // Item operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  // Register index decoded from the word address.
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = CNT_W'(6);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_STEP
  } gdfs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_row;
    logic start_run;
    logic root_adv;
    logic root_emit;
    logic step_pop;
    logic step_emit;
  } gdfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_done;
    logic root_visited;
    logic open_none;
    logic level_one;
    logic emit_ok;
  } gdfs_status_t;

endpackage

/* rtl/core/gdfs_ctrl.sv */
`timescale 1ns / 1ps

module gdfs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_op_i,
  output logic                  in_ready_o,
  input  gdfs_pkg::gdfs_status_t status_i,
  output gdfs_pkg::gdfs_cmd_t    cmd_o
);
  import gdfs_pkg::*;

  gdfs_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_op_i == OP_RUN)) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (status_i.root_done) begin
          state_d = ST_IDLE;
        end else if (!status_i.root_visited && status_i.emit_ok) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status_i.open_none && status_i.level_one) begin
          state_d = ST_ROOT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic: handshake and datapath commands.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.write_row = (in_op_i == OP_WRITE);
          cmd_o.start_run = (in_op_i == OP_RUN);
        end
      end
      ST_ROOT: begin
        if (!status_i.root_done) begin
          if (status_i.root_visited) begin
            cmd_o.root_adv = 1'b1;
          end else if (status_i.emit_ok) begin
            cmd_o.root_emit = 1'b1;
          end
        end
      end
      ST_STEP: begin
        if (status_i.open_none) begin
          cmd_o.step_pop = 1'b1;
          // Leaving the last stack level finishes this root.
          cmd_o.root_adv = status_i.level_one;
        end else if (status_i.emit_ok) begin
          cmd_o.step_emit = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/gdfs_dp.sv */
`timescale 1ns / 1ps
`include "graph_dfs_visit_order_defines.svh"

module gdfs_dp #(
  parameter int ROWS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gdfs_pkg::gdfs_cmd_t               cmd_i,
  output gdfs_pkg::gdfs_status_t            status_o,
  input  logic [gdfs_pkg::CNT_W-1:0]        count_i,
  input  logic [gdfs_pkg::VTX_W-1:0]        row_index_i,
  input  logic [gdfs_pkg::ROW_W-1:0]        row_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gdfs_pkg::VTX_W-1:0]        visited_vertex_o,
  output logic                              last_visit_o
);
  import gdfs_pkg::*;

  localparam int IDX_W = $clog2(ROWS);

  logic [ROW_W-1:0] rows_q [ROWS];
  logic [VTX_W-1:0] stack_q [ROWS];
  logic [ROW_W-1:0] visited_q;
  logic [CNT_W-1:0] root_q;
  logic [CNT_W-1:0] level_q;
  logic [CNT_W-1:0] vcount_q;
  logic             out_valid_q;
  logic [VTX_W-1:0] out_vertex_q;
  logic             out_last_q;

  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] open_set;
  logic [ROW_W-1:0] adj_row;
  logic [CNT_W-1:0] level_dec;
  logic [VTX_W-1:0] here;
  logic [VTX_W-1:0] next_vtx;
  logic [VTX_W-1:0] emit_vtx;
  logic             emit;
  logic [CNT_W-1:0] vcount_inc;

  // Vertices at or above the active count are masked out.
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      mask[j] = (CNT_W'(j) < count_i);
    end
  end

  // Top of the stack and its still-open neighbors.
  assign level_dec = level_q - 1'b1;
  assign here      = stack_q[level_dec[IDX_W-1:0]];
  assign adj_row   = rows_q[here[IDX_W-1:0]];
  assign open_set  = adj_row & mask & ~visited_q;

  // Lowest-numbered open neighbor.
  always_comb begin
    next_vtx = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (open_set[j]) begin
        next_vtx = VTX_W'(j);
      end
    end
  end

  assign emit       = cmd_i.root_emit || cmd_i.step_emit;
  assign emit_vtx   = cmd_i.root_emit ? root_q[VTX_W-1:0] : next_vtx;
  assign vcount_inc = vcount_q + 1'b1;

  // Status toward the controller.
  always_comb begin
    status_o.root_done    = (root_q == count_i);
    status_o.root_visited = visited_q[root_q[VTX_W-1:0]];
    status_o.open_none    = (open_set == '0);
    status_o.level_one    = (level_q == CNT_W'(1));
    status_o.emit_ok      = !out_valid_q || out_ready_i;
  end

  // Adjacency rows; rows beyond the storage are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        rows_q[r] <= '0;
      end
    end else if (cmd_i.write_row && ({1'b0, row_index_i} < (VTX_W + 1)'(ROWS))) begin
      rows_q[row_index_i[IDX_W-1:0]] <= row_bits_i;
    end
  end

  // Path stack; not reset, so entries from earlier runs stay until overwritten.
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_emit) begin
      stack_q[0] <= root_q[VTX_W-1:0];
    end else if (cmd_i.step_emit && (level_q < count_i)) begin
      stack_q[level_q[IDX_W-1:0]] <= next_vtx;
    end
  end

  // Traversal state: visited marks, root cursor, stack level, visit count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      root_q    <= '0;
      level_q   <= '0;
      vcount_q  <= '0;
    end else begin
      if (cmd_i.start_run) begin
        visited_q <= '0;
        root_q    <= '0;
        level_q   <= '0;
        vcount_q  <= '0;
      end else begin
        if (emit) begin
          visited_q[emit_vtx] <= 1'b1;
          vcount_q            <= vcount_inc;
        end
        if (cmd_i.root_adv) begin
          root_q <= root_q + 1'b1;
        end
        if (cmd_i.root_emit) begin
          level_q <= CNT_W'(1);
        end else if (cmd_i.step_emit && (level_q < count_i)) begin
          level_q <= level_q + 1'b1;
        end else if (cmd_i.step_pop) begin
          level_q <= level_dec;
        end
      end
    end
  end

  // Output register. Every active vertex is visited once, so the run
  // ends with the visit that brings the count up to the vertex count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_vertex_q <= emit_vtx;
      out_last_q   <= (vcount_inc == count_i);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign visited_vertex_o = out_vertex_q;
  assign last_visit_o     = out_last_q;

  // A new item only enters the output register when the slot is free.
  `GDFS_ASSERT_NOW(a_emit_slot_free, emit, (!out_valid_q || out_ready_i), "item emitted into a full output slot")
  // A neighbor step never revisits a vertex.
  `GDFS_ASSERT_NOW(a_step_unvisited, cmd_i.step_emit, (!visited_q[next_vtx]), "step emitted a visited vertex")
  // A new root starts only on an empty stack.
  `GDFS_ASSERT_NOW(a_root_empty_stack, cmd_i.root_emit, (level_q == '0), "root started on a nonempty stack")
  // The stack level stays within the stack storage.
  `GDFS_ASSERT_NEXT(a_level_bound, 1'b1, (level_q <= CNT_W'(ROWS)), "stack level beyond storage")

endmodule

/* rtl/core/graph_dfs_visit_order.sv */
`timescale 1ns / 1ps
// Depth-first visit order over an adjacency matrix of up to 16 vertices.
// Input channel (in_valid_i / in_ready_o): op_i = 0 writes row_bits_i into
// adjacency row row_index_i; op_i = 1 starts a run. A run clears
// the visited marks and walks depth first from every unvisited root in
// ascending order, always going to the lowest-numbered unvisited neighbor.
// Output channel (out_valid_o / out_ready_i): one item per active vertex, the
// active count being vertex_count saturated at 16, last_visit_o on the final one.
// Register vertex_count lies at byte address 0 of the APB port (reset 6).
// Timing: write items can follow back to back. A run holds the input off until
// it is done, taking a step for each visit, each pop and each root that is found
// already visited, and a final step to finish; a stalled receiver adds to this.
// The first result is registered in the output register after the controller
// has entered its root state, unless the previous result is still waiting.
// When the receiver stalls, the traversal pauses on the next visit until the
// output register is free; nothing is dropped.
// Reset clears the adjacency rows, the visited marks and the stack level, and
// sets vertex_count to 6.

module graph_dfs_visit_order #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [gdfs_pkg::VTX_W-1:0]        row_index_i,
  input  logic [gdfs_pkg::ROW_W-1:0]        row_bits_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gdfs_pkg::VTX_W-1:0]        visited_vertex_o,
  output logic                              last_visit_o
);
  import gdfs_pkg::*;

  localparam int ROWS = (MAX_VERTICES < VTX_LIMIT) ? MAX_VERTICES : VTX_LIMIT;

  logic [CNT_W-1:0] vertex_count_q;
  logic [CNT_W-1:0] count_eff;
  logic             reg_sel;
  gdfs_cmd_t        cmd;
  gdfs_status_t     status;

  // Register decode on the word address.
  assign reg_sel = (paddr[2] == REG_VERTEX_COUNT);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      vertex_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32 - CNT_W){1'b0}}, vertex_count_q} : '0;

  // The count in use saturates at the stored row count.
  assign count_eff = (vertex_count_q > CNT_W'(ROWS)) ? CNT_W'(ROWS) : vertex_count_q;

  gdfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (op_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gdfs_dp #(
    .ROWS (ROWS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .count_i          (count_eff),
    .row_index_i      (row_index_i),
    .row_bits_i       (row_bits_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .visited_vertex_o (visited_vertex_o),
    .last_visit_o     (last_visit_o)
  );

endmodule

/* sim/gdfs_visit_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration port and both item channels of the traversal block.
// It keeps its own copy of the adjacency matrix and of vertex_count, and works
// out the expected visit order for every accepted run item. It compares each
// accepted result item against the oldest expected visit.
module gdfs_visit_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port, observed
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  // input items, observed
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       op_i,
  input  logic [gdfs_pkg::VTX_W-1:0] row_index_i,
  input  logic [gdfs_pkg::ROW_W-1:0] row_bits_i,
  // result items, observed
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [gdfs_pkg::VTX_W-1:0] visited_vertex_i,
  input  logic                       last_visit_i,
  // status for the stimulus side
  output int                         outstanding_o,
  output int                         failures_o,
  output int                         visits_o
);
  import gdfs_pkg::*;

  localparam logic [2:0] VC_ADDR = 3'(4 * int'(REG_VERTEX_COUNT));

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
  } visit_t;

  logic [ROW_W-1:0] adj_rows [VTX_LIMIT];
  logic [CNT_W-1:0] vtx_count;
  visit_t           visit_q [$];
  int               fails;
  int               checked;

  // Depth-first walk over the shadow matrix; appends one visit per vertex
  // reached and flags the final one of the run.
  function automatic void predict_visit_order();
    logic [VTX_LIMIT-1:0] seen;
    logic [VTX_LIMIT-1:0] span;
    logic [VTX_LIMIT-1:0] avail;
    logic [VTX_W-1:0]     trail [VTX_LIMIT];
    logic [VTX_W-1:0]     order [$];
    visit_t               entry;
    int                   n;
    int                   depth;
    int                   here;
    int                   nxt;
    n = (int'(vtx_count) > VTX_LIMIT) ? VTX_LIMIT : int'(vtx_count);
    span = (n >= VTX_LIMIT) ? '1 : VTX_LIMIT'((1 << n) - 1);
    seen = '0;
    for (int root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1'b1;
        order.insert(order.size(), VTX_W'(root));
        trail[0] = VTX_W'(root);
        depth = 1;
        while (depth > 0) begin
          here = int'(trail[depth-1]);
          avail = adj_rows[here] & span & ~seen;
          if (avail == '0) begin
            depth--;
          end else begin
            // Lowest-numbered unvisited neighbor goes next.
            nxt = 0;
            while (!avail[nxt]) nxt++;
            seen[nxt] = 1'b1;
            order.insert(order.size(), VTX_W'(nxt));
            if (depth < n) begin
              trail[depth] = VTX_W'(nxt);
              depth++;
            end
          end
        end
      end
    end
    foreach (order[i]) begin
      entry.vertex = order[i];
      entry.last   = (i == order.size() - 1);
      visit_q.insert(visit_q.size(), entry);
    end
  endfunction

  // Shadow state update and result comparison, all sampled at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    visit_t want;
    if (!rst_ni) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vtx_count = VERTEX_COUNT_RST;
      visit_q.delete();
      fails = 0;
      checked = 0;
      outstanding_o <= 0;
      failures_o <= 0;
      visits_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == VC_ADDR) begin
        vtx_count = pwdata[CNT_W-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        if (op_i == OP_WRITE) begin
          adj_rows[row_index_i] = row_bits_i;
        end else begin
          predict_visit_order();
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (visit_q.size() == 0) begin
          $error("unexpected result item: visited_vertex %0d last_visit %0d",
                 visited_vertex_i, last_visit_i);
          fails++;
        end else begin
          want = visit_q.pop_front();
          checked++;
          if (visited_vertex_i !== want.vertex) begin
            $error("visited_vertex: expected %0d, got %0d", want.vertex,
                   visited_vertex_i);
            fails++;
          end
          if (last_visit_i !== want.last) begin
            $error("last_visit: expected %0d, got %0d", want.last, last_visit_i);
            fails++;
          end
        end
      end
      outstanding_o <= visit_q.size();
      failures_o <= fails;
      visits_o <= checked;
    end
  end

endmodule

/* sim/graph_dfs_visit_order_tb.sv */
`timescale 1ns / 1ps

module graph_dfs_visit_order_tb;
  import gdfs_pkg::*;

  localparam int          SETTLE_CYCLES = 64;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          RANDOM_ITEMS  = 340;
  localparam logic [2:0]  VC_ADDR       = 3'(4 * int'(REG_VERTEX_COUNT));

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              op_i;
  logic [VTX_W-1:0]  row_index_i;
  logic [ROW_W-1:0]  row_bits_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [VTX_W-1:0]  visited_vertex_o;
  logic              last_visit_o;

  int outstanding;
  int failures;
  int visits;
  int cycles;
  int items_sent;
  int runs_sent;
  int writes_sent;
  int settings_used;
  bit steady;
  bit hold_req;

  graph_dfs_visit_order dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .row_index_i      (row_index_i),
    .row_bits_i       (row_bits_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .visited_vertex_o (visited_vertex_o),
    .last_visit_o     (last_visit_o)
  );

  gdfs_visit_checker u_visit_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .op_i             (op_i),
    .row_index_i      (row_index_i),
    .row_bits_i       (row_bits_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .visited_vertex_i (visited_vertex_o),
    .last_visit_i     (last_visit_o),
    .outstanding_o    (outstanding),
    .failures_o       (failures),
    .visits_o         (visits)
  );

  // Free-running clock, 20 ns period.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cycle budget; ends the run if the block hangs.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("graph_dfs_visit_order verification failed");
    $finish;
  end

  // Result receiver: random back-pressure, a quiet window, and one long hold-off.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 30);
      end
    end
  end

  // Offers one item, after random idle cycles unless steady, and waits for acceptance.
  task automatic send_item(input logic op, input logic [VTX_W-1:0] row,
                           input logic [ROW_W-1:0] bits);
    if (!steady) begin
      while ($urandom_range(99) < 30) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    row_index_i <= row;
    row_bits_i <= bits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (op == OP_RUN) runs_sent++;
    else writes_sent++;
  endtask

  // Stops offering items until every expected visit has come back and the
  // block has had time to finish a run that produced nothing.
  task automatic wait_visits_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup and access cycle on the configuration port; upper data bits are junk.
  task automatic write_vertex_count(input logic [CNT_W-1:0] value);
    wait_visits_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= VC_ADDR;
    pwdata <= {27'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_used++;
  endtask

  // Stimulus and verdict.
  initial begin
    logic [ROW_W-1:0] graph [VTX_LIMIT];
    int               perm [VTX_LIMIT];
    int               eff;
    int               style;
    int               pick;
    int               tmp;
    int               parent;
    int               phase;
    logic [CNT_W-1:0] cnt;

    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    op_i <= OP_WRITE;
    row_index_i <= '0;
    row_bits_i <= '0;
    steady = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    runs_sent = 0;
    writes_sent = 0;
    settings_used = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part at the reset count of six: empty graph, self loops,
    // edges and rows beyond the count, a back edge.
    send_item(OP_RUN, 4'd0, 16'h0000);
    send_item(OP_WRITE, 4'd0, 16'hFFFF);
    send_item(OP_WRITE, 4'd15, 16'hFFFF);
    send_item(OP_WRITE, 4'd2, 16'h0014);
    send_item(OP_RUN, 4'd9, 16'hA5A5);
    send_item(OP_WRITE, 4'd5, 16'h0001);
    send_item(OP_RUN, 4'd0, 16'h0000);
    // Full sixteen vertices, then zero, a saturating count, and one vertex.
    write_vertex_count(5'd16);
    send_item(OP_RUN, 4'd0, 16'h0000);
    send_item(OP_WRITE, 4'd0, 16'h0000);
    send_item(OP_WRITE, 4'd9, 16'h8000);
    send_item(OP_WRITE, 4'd15, 16'h0200);
    send_item(OP_RUN, 4'd0, 16'h0000);
    write_vertex_count(5'd0);
    send_item(OP_RUN, 4'd0, 16'h0000);
    write_vertex_count(5'd31);
    send_item(OP_RUN, 4'd15, 16'hFFFF);
    write_vertex_count(5'd1);
    send_item(OP_RUN, 4'd0, 16'h0000);
    send_item(OP_WRITE, 4'd0, 16'h0001);
    send_item(OP_RUN, 4'd0, 16'h0000);
    write_vertex_count(5'd17);
    send_item(OP_RUN, 4'd0, 16'h0000);

    // Random part: each phase picks a count, then builds graphs and runs them.
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = (phase == 5 || phase == 6);
      pick = $urandom_range(9);
      if (phase == 3) cnt = 5'd16;
      else if (pick == 0) cnt = 5'd0;
      else if (pick == 1) cnt = 5'd16;
      else if (pick == 2) cnt = 5'($urandom_range(17, 31));
      else if (pick == 3) cnt = 5'd1;
      else cnt = 5'($urandom_range(2, 15));
      write_vertex_count(cnt);
      eff = (int'(cnt) > VTX_LIMIT) ? VTX_LIMIT : int'(cnt);

      // Long receiver hold-off while runs keep arriving.
      if (phase == 3) begin
        hold_req = 1'b1;
        repeat (3) send_item(OP_RUN, 4'($urandom), 16'($urandom));
      end

      repeat ($urandom_range(2, 4)) begin
        style = $urandom_range(9);
        if (style <= 4) begin
          // A few random rows, mostly inside the count, sparse or dense.
          repeat ($urandom_range(1, 6)) begin
            if (eff > 0 && $urandom_range(9) < 8) tmp = $urandom_range(0, eff - 1);
            else tmp = $urandom_range(0, 15);
            if ($urandom_range(1)) send_item(OP_WRITE, 4'(tmp), 16'($urandom & $urandom));
            else send_item(OP_WRITE, 4'(tmp), 16'($urandom));
          end
        end else if (style <= 7) begin
          // Whole graph: a path or a tree over a shuffled vertex order.
          foreach (perm[i]) perm[i] = i;
          for (int i = eff - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[pick];
            perm[pick] = tmp;
          end
          foreach (graph[i]) graph[i] = '0;
          for (int i = 1; i < eff; i++) begin
            parent = (style == 7) ? perm[$urandom_range(0, i - 1)] : perm[i - 1];
            graph[parent][perm[i]] = 1'b1;
            if ($urandom_range(3) == 0) graph[perm[i]][parent] = 1'b1;
          end
          for (int i = 0; i < eff; i++) send_item(OP_WRITE, 4'(i), graph[i]);
        end else if (style == 8) begin
          // Noise: rows outside the count and back-to-back runs.
          send_item(OP_WRITE, 4'($urandom_range(eff > 15 ? 15 : eff, 15)),
                    16'($urandom));
          send_item(OP_RUN, 4'($urandom), 16'($urandom));
        end
        if (style != 9) send_item(OP_RUN, 4'($urandom), 16'($urandom));
      end
      phase++;
    end

    steady = 1'b0;
    wait_visits_drained();
    $display("Covered %0d runs and %0d row writes over %0d vertex-count settings,",
             runs_sent, writes_sent, settings_used);
    $display("with %0d visit results compared against the predicted order.", visits);
    if (failures == 0) begin
      $display("graph_dfs_visit_order verification clean");
    end else begin
      $display("graph_dfs_visit_order verification failed");
    end
    $finish;
  end

endmodule

/* graph_dfs_visit_order.f */
+incdir+rtl/core
rtl/core/gdfs_pkg.sv
rtl/core/gdfs_ctrl.sv
rtl/core/gdfs_dp.sv
rtl/core/graph_dfs_visit_order.sv
sim/gdfs_visit_checker.sv
sim/graph_dfs_visit_order_tb.sv
